// ===== src/ultrasonic_echo_ranger_core_macros.svh =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger assertion macros
// Shared concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_CORE_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define UER_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ranger assertion failed");

// Next-cycle implication, checked out of reset.
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ranger assertion failed");

`else

`define UER_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Beat types, register indexes, reset values and distance scaling constants.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int CFG_W          = 17;
    localparam int OFFSET_W       = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int COUNT_BITS_DEF = 17;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_OFFSET  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REAR_OFFSET   = 2'd3;

    localparam logic [CFG_W-1:0]    TRIGGER_TICKS_RST = 17'd10000;
    localparam logic [CFG_W-1:0]    ECHO_TIMEOUT_RST  = 17'd100000;
    localparam logic [OFFSET_W-1:0] FRONT_OFFSET_RST  = 8'd60;
    localparam logic [OFFSET_W-1:0] REAR_OFFSET_RST   = 8'd50;

    // Half-count clamp: any larger half count saturates the raw distance at 22536.
    localparam int HALF_W                = 17;
    localparam logic [HALF_W-1:0] HALF_CLAMP = 17'd66283;

    // Scaled value is floor(half*17/2); distance = floor(scaled/25).
    localparam int SCALED_W    = 20;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 25;
    localparam logic [RECIP_W-1:0] RECIP_25 = 21'd1342178;
    localparam int QUOT_W      = 16;

    localparam logic signed [15:0] DIST_MAX     = 16'sd22281;
    localparam logic signed [15:0] DIST_TIMEOUT = 16'sd9999;

    typedef struct packed {
        logic start_req;
        logic front_select;
        logic echo_level;
    } in_item_t;

    typedef struct packed {
        logic               trigger_out;
        logic               busy_res;
        logic               done_res;
        logic               timed_out;
        logic signed [15:0] distance_mm;
        logic signed [15:0] last_front_mm;
        logic signed [15:0] last_rear_mm;
    } out_item_t;

    // Record handed from the tick stage to the distance stage.
    typedef struct packed {
        logic                trigger;
        logic                busy;
        logic                done;
        logic                timed_out;
        logic                meas_ok;
        logic                side_front;
        logic [SCALED_W-1:0] scaled;
    } stage_rec_t;

endpackage

// ===== src/uer_tick.sv =====
// ----------------------------------------------------------------------------
// Ranger tick stage
// Phase machine and tick counter, advanced once per accepted beat.
// ----------------------------------------------------------------------------
module uer_tick #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic                       take,
    input  uer_pkg::in_item_t          item,
    input  logic [uer_pkg::CFG_W-1:0]  trigger_ticks,
    input  logic [uer_pkg::CFG_W-1:0]  echo_timeout,
    output logic                       rec_valid,
    output uer_pkg::stage_rec_t        rec
);
    import uer_pkg::*;

    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int HW    = ((COUNT_BITS - 1) > HALF_W) ? (COUNT_BITS - 1) : HALF_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_RISE, PH_MEAS} phase_t;

    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next, cnt_inc;
    logic                  side_reg, side_next;
    logic                  valid_reg;
    stage_rec_t            rec_reg, rec_next;
    logic                  cnt_full, trig_end, wait_over, done, tmo, meas_ok;
    logic [HW-1:0]         half_ext;
    logic [HALF_W-1:0]     half_c;
    logic [HALF_W+3:0]     times17;

    always_comb
    begin
        cnt_full  = (cnt_reg == CNT_MAX);
        cnt_inc   = cnt_full ? cnt_reg : cnt_reg + 1'b1;
        trig_end  = (CMP_W'(cnt_inc) >= CMP_W'(trigger_ticks)) || (cnt_inc == CNT_MAX);
        wait_over = (CMP_W'(cnt_inc) > CMP_W'(echo_timeout)) || (cnt_inc == CNT_MAX);

        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        side_next  = side_reg;
        done       = 1'b0;
        tmo        = 1'b0;
        meas_ok    = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (item.start_req)
                begin
                    side_next  = item.front_select;
                    cnt_next   = '0;
                    phase_next = PH_TRIG;
                end
            end
            PH_TRIG:
            begin
                cnt_next = cnt_inc;
                if (trig_end)
                begin
                    phase_next = PH_RISE;
                    cnt_next   = '0;
                end
            end
            PH_RISE:
            begin
                cnt_next = cnt_inc;
                if (item.echo_level)
                begin
                    phase_next = PH_MEAS;
                    cnt_next   = '0;
                end
                else if (wait_over)
                begin
                    done = 1'b1;
                    tmo  = 1'b1;
                end
            end
            PH_MEAS:
            begin
                cnt_next = cnt_inc;
                if (!item.echo_level)
                begin
                    done    = 1'b1;
                    meas_ok = 1'b1;
                end
                else if (wait_over)
                begin
                    done = 1'b1;
                    tmo  = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (done)
        begin
            phase_next = PH_IDLE;
            cnt_next   = '0;
        end

        // Pre-scale the pulse width: clamp the half count, then times 17 over 2.
        half_ext = HW'(cnt_inc >> 1);
        half_c   = (half_ext > HW'(HALF_CLAMP)) ? HALF_CLAMP : half_ext[HALF_W-1:0];
        times17  = {half_c, 4'b0000} + (HALF_W+4)'(half_c);

        rec_next.trigger    = (phase_next == PH_TRIG);
        rec_next.busy       = (phase_next != PH_IDLE);
        rec_next.done       = done;
        rec_next.timed_out  = tmo;
        rec_next.meas_ok    = meas_ok;
        rec_next.side_front = side_reg;
        rec_next.scaled     = times17[HALF_W+3:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            side_reg  <= 1'b0;
            valid_reg <= 1'b0;
            rec_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                side_reg  <= side_next;
                rec_reg   <= rec_next;
                valid_reg <= 1'b1;
            end
            else if (take)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign rec_valid = valid_reg;
    assign rec       = rec_reg;

endmodule

// ===== src/uer_dist.sv =====
// ----------------------------------------------------------------------------
// Ranger distance stage
// Divides the scaled width by 25, applies the side offset, keeps readings.
// ----------------------------------------------------------------------------
module uer_dist (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rec_valid,
    input  uer_pkg::stage_rec_t           rec,
    input  logic [uer_pkg::OFFSET_W-1:0]  front_offset,
    input  logic [uer_pkg::OFFSET_W-1:0]  rear_offset,
    input  logic                          out_stall,
    output logic                          ready,
    output logic                          out_valid,
    output uer_pkg::out_item_t            out_data
);
    import uer_pkg::*;

    logic                              valid_reg;
    out_item_t                         out_reg, out_next;
    logic signed [15:0]                front_reg, front_next, rear_reg, rear_next;
    logic [SCALED_W+RECIP_W-1:0]       prod;
    logic [QUOT_W-1:0]                 quot;
    logic [OFFSET_W-1:0]               offset;
    logic signed [QUOT_W:0]            diff;
    logic signed [15:0]                dist_sat;
    logic                              load;

    always_comb
    begin
        prod     = SCALED_W'(rec.scaled) * RECIP_25;
        quot     = prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
        offset   = rec.side_front ? front_offset : rear_offset;
        diff     = $signed({1'b0, quot}) - $signed((QUOT_W+1)'(offset));
        dist_sat = (diff > (QUOT_W+1)'(DIST_MAX)) ? DIST_MAX : diff[15:0];

        front_next = front_reg;
        rear_next  = rear_reg;
        if (rec.meas_ok && rec.side_front)
        begin
            front_next = dist_sat;
        end
        if (rec.meas_ok && !rec.side_front)
        begin
            rear_next = dist_sat;
        end

        out_next.trigger_out   = rec.trigger;
        out_next.busy_res      = rec.busy;
        out_next.done_res      = rec.done;
        out_next.timed_out     = rec.timed_out;
        out_next.distance_mm   = rec.timed_out ? DIST_TIMEOUT
                                               : (rec.meas_ok ? dist_sat : 16'sd0);
        out_next.last_front_mm = front_next;
        out_next.last_rear_mm  = rear_next;
    end

    assign ready = !valid_reg || !out_stall;
    assign load  = rec_valid && ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            front_reg <= '0;
            rear_reg  <= '0;
            out_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                front_reg <= front_next;
                rear_reg  <= rear_next;
                out_reg   <= out_next;
            end
            else if (ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== src/ultrasonic_echo_ranger_core.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger core
// Trigger/echo timing and distance computation, one input beat per tick.
// ----------------------------------------------------------------------------
// An accepted beat is registered in the tick stage, then in the distance stage.
// Throughput: one beat per cycle without out_stall; the tick stage holds the
// phase machine and counter, the distance stage one 20x21 reciprocal multiply.
// Reset: asynchronous, active low; phase idle, counter and readings zero,
// registers at trigger 10000, timeout 100000, offsets 60 front and 50 rear.
`include "ultrasonic_echo_ranger_core_macros.svh"

module ultrasonic_echo_ranger_core #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  uer_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output uer_pkg::out_item_t             out_data,
    input  logic                           cfg_write,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uer_pkg::CFG_W-1:0]      cfg_data
);
    import uer_pkg::*;

    // Configuration registers. They must only be written while no beat is in
    // flight, so both stages may read them directly; the block does not enforce this.
    logic [CFG_W-1:0]    trigger_ticks_reg;
    logic [CFG_W-1:0]    echo_timeout_reg;
    logic [OFFSET_W-1:0] front_offset_reg;
    logic [OFFSET_W-1:0] rear_offset_reg;

    // Pipeline handshake. The tick stage loads on every accepted beat; its
    // record moves on whenever the output register is free or being drained,
    // so a new beat is still taken while a finished result waits downstream if the tick stage holds no record.
    logic       accept;
    logic       s1_valid;
    logic       s2_ready;
    stage_rec_t s1_rec;

    assign in_stall = s1_valid && !s2_ready;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg <= TRIGGER_TICKS_RST;
            echo_timeout_reg  <= ECHO_TIMEOUT_RST;
            front_offset_reg  <= FRONT_OFFSET_RST;
            rear_offset_reg   <= REAR_OFFSET_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TRIGGER_TICKS: trigger_ticks_reg <= cfg_data;
                REG_ECHO_TIMEOUT:  echo_timeout_reg  <= cfg_data;
                REG_FRONT_OFFSET:  front_offset_reg  <= cfg_data[OFFSET_W-1:0];
                REG_REAR_OFFSET:   rear_offset_reg   <= cfg_data[OFFSET_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Stage one: the phase machine steps once per beat, decides trigger,
    // busy, done and timeout, and pre-scales the echo width.
    uer_tick #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tick (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .take          (s2_ready),
        .item          (in_data),
        .trigger_ticks (trigger_ticks_reg),
        .echo_timeout  (echo_timeout_reg),
        .rec_valid     (s1_valid),
        .rec           (s1_rec)
    );

    // Stage two: divide by 25 through a reciprocal multiply, subtract the
    // side's offset, saturate, and update the stored front or rear reading.
    uer_dist u_dist (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_valid    (s1_valid),
        .rec          (s1_rec),
        .front_offset (front_offset_reg),
        .rear_offset  (rear_offset_reg),
        .out_stall    (out_stall),
        .ready        (s2_ready),
        .out_valid    (out_valid),
        .out_data     (out_data)
    );

    // A timeout result always carries done and the fixed timeout distance.
    `UER_ASSERT_NOW(a_timeout_dist, clk, rst_n, out_valid && out_data.timed_out, out_data.done_res && (out_data.distance_mm == DIST_TIMEOUT))

    // The trigger is only driven during a measurement.
    `UER_ASSERT_NOW(a_trigger_busy, clk, rst_n, out_valid && out_data.trigger_out, out_data.busy_res)

    // Beats without done report zero distance.
    `UER_ASSERT_NOW(a_idle_dist, clk, rst_n, out_valid && !out_data.done_res, out_data.distance_mm == 16'sd0)

    // Input is only held off while the tick stage has a record that cannot move.
    `UER_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, s1_valid && out_valid && out_stall)

endmodule
